FILE: rtl/signed_int_to_decimal_ascii_assert.svh
// Assertion macros for the signed_int_to_decimal_ascii checker.
// Expects a clock named clock and a synchronous reset named reset in scope.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SIDTA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sidta assertion failed");

// Next-cycle implication, checked outside reset.
`define SIDTA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sidta assertion failed");

`endif

FILE: rtl/sidta_pkg.sv
// Shared constants and controller/datapath interface types for
// signed_int_to_decimal_ascii. No dependencies.
package sidta_pkg;

   localparam int VALUE_WIDTH   = 32;
   localparam int CHAR_W        = 7;
   localparam int BITS_PER_STEP = 4;
   localparam int SHIFT_STEPS   = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_W         = SHIFT_STEPS * BITS_PER_STEP;
   // Decimal digits of 2**VALUE_WIDTH - 1: floor(W * log10(2)) + 1
   localparam int NDIG          = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W         = NDIG * 4;
   localparam int STEP_W        = $clog2(SHIFT_STEPS);
   localparam int IDX_W         = $clog2(NDIG);

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

   typedef struct packed {
      logic load;        // capture a new value
      logic shift;       // one conversion step
      logic find;        // locate leading digit
      logic next_digit;  // advance to next lower digit
      logic sel_sign;    // present the minus sign
   } cmd_type;

   typedef struct packed {
      logic shift_done;
      logic negative;
      logic last_digit;
   } status_type;

endpackage

FILE: rtl/sidta_ctrl.sv
// Sequencer for signed_int_to_decimal_ascii: handshakes and datapath commands.
// Depends on sidta_pkg.
module sidta_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sidta_pkg::cmd_type    cmd,
   input  sidta_pkg::status_type status
);
   import sidta_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      CONVERT,
      LOCATE,
      SIGN,
      DIGITS
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CONVERT;
            end
         end
         CONVERT: begin
            cmd.shift = 1'b1;
            if (status.shift_done) begin
               state_in = LOCATE;
            end
         end
         LOCATE: begin
            cmd.find = 1'b1;
            state_in = status.negative ? SIGN : DIGITS;
         end
         SIGN: begin
            cmd.sel_sign = 1'b1;
            if (rsp_ready) begin
               state_in = DIGITS;
            end
         end
         DIGITS: begin
            if (rsp_ready) begin
               if (status.last_digit) begin
                  state_in = IDLE;
               end else begin
                  cmd.next_digit = 1'b1;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
      req_ready_in = (state_in == IDLE);
      rsp_valid_in = state_in inside {SIGN, DIGITS};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/sidta_datapath.sv
// Datapath for signed_int_to_decimal_ascii: magnitude, shift-add-3 BCD
// conversion, leading digit search and character select. Depends on sidta_pkg.
module sidta_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic signed [sidta_pkg::VALUE_WIDTH-1:0] req_value,
   input  sidta_pkg::cmd_type                      cmd,
   output sidta_pkg::status_type                   status,
   output logic [sidta_pkg::CHAR_W-1:0]            rsp_character,
   output logic                                    rsp_last
);
   import sidta_pkg::*;

   logic [PAD_W-1:0]       mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   neg_ff, neg_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] abs_val;
   logic [BCD_W-1:0]       bcd_step;
   logic [PAD_W-1:0]       mag_step;
   logic [IDX_W-1:0]       lead_idx;
   logic [3:0]             cur_digit;

   assign raw     = req_value;
   assign abs_val = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

   // Four shift-add-3 steps per cycle, most significant magnitude bit first.
   always_comb begin
      bcd_step = bcd_ff;
      mag_step = mag_ff;
      for (int s = 0; s < BITS_PER_STEP; s++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (bcd_step[d*4 +: 4] >= 4'd5) begin
               bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
         end
         {bcd_step, mag_step} = {bcd_step[BCD_W-2:0], mag_step, 1'b0};
      end
   end

   // Highest nonzero digit; zero keeps index 0 so a lone '0' is sent.
   always_comb begin
      lead_idx = '0;
      for (int d = 0; d < NDIG; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            lead_idx = IDX_W'(d);
         end
      end
   end

   always_comb begin
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      idx_in  = idx_ff;
      neg_in  = neg_ff;
      if (cmd.load) begin
         neg_in  = raw[VALUE_WIDTH-1];
         mag_in  = PAD_W'(abs_val);
         bcd_in  = '0;
         step_in = '0;
      end else if (cmd.shift) begin
         mag_in  = mag_step;
         bcd_in  = bcd_step;
         step_in = step_ff + 1'b1;
      end else if (cmd.find) begin
         idx_in = lead_idx;
      end else if (cmd.next_digit) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      idx_ff <= idx_in;
      neg_ff <= neg_in;
   end

   assign cur_digit = bcd_ff[idx_ff*4 +: 4];

   assign status.shift_done = (step_ff == STEP_W'(SHIFT_STEPS - 1));
   assign status.negative   = neg_ff;
   assign status.last_digit = (idx_ff == '0);

   assign rsp_character = cmd.sel_sign ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(cur_digit));
   assign rsp_last      = !cmd.sel_sign && (idx_ff == '0);

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Converts one signed two's complement value per transfer into its decimal
// ASCII text, one character per rsp transfer: '-' first for a negative value,
// then the digits most significant first without leading zeros, rsp_last on
// the final one. After a req transfer the value is converted to BCD by a
// shift-add-3 loop handling four bits per cycle, the LOCATE state then finds
// the leading digit, and one character leaves per cycle while rsp_ready is
// high. No new value is taken until the last character has gone: req_ready
// returns the cycle after the last character's transfer. Depends on
// sidta_pkg, sidta_ctrl and sidta_datapath.
module signed_int_to_decimal_ascii (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [sidta_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic [sidta_pkg::CHAR_W-1:0]            rsp_character,
   output logic                                    rsp_last
);
   import sidta_pkg::*;

   cmd_type    cmd;
   status_type status;

   sidta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   sidta_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: rtl/sidta_checker.sv
// Port-level checks for signed_int_to_decimal_ascii, bound to the top level.
// Depends on sidta_pkg and signed_int_to_decimal_ascii_assert.svh.
`include "signed_int_to_decimal_ascii_assert.svh"

module sidta_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic [sidta_pkg::CHAR_W-1:0]            rsp_character,
   input logic                                    rsp_last
);
   import sidta_pkg::*;

   logic rsp_xfer;
   logic req_xfer;
   logic rsp_stall;
   logic sign_xfer;
   logic lead_digit;

   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign req_xfer   = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign sign_xfer  = rsp_xfer && (rsp_character == CHAR_MINUS);
   assign lead_digit = (rsp_character != CHAR_MINUS) && (rsp_character != CHAR_ZERO);

   // A stalled character holds.
   `SIDTA_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable({rsp_character, rsp_last}))
   // Never take a new value while text is still going out.
   `SIDTA_ASSERT_NOW(a_busy_excl, rsp_valid, !req_ready)
   // A run continues without gaps until its last character.
   `SIDTA_ASSERT_NEXT(a_run_unbroken, rsp_xfer && !rsp_last, rsp_valid)
   // A minus sign is followed by a nonzero leading digit.
   `SIDTA_ASSERT_NEXT(a_sign_then_digit, sign_xfer, rsp_valid && lead_digit)
   // Conversion runs before any character shows after a req transfer.
   `SIDTA_ASSERT_NEXT(a_convert_gap, req_xfer, !rsp_valid)

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_sidta_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);
